// ===== src/mpsn_pkg.sv =====
// shared types and register codes for the pixel sample normalizer
`default_nettype none
package mpsn_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 5;

	// register indexes on the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_BYTE_SWAP   = 3'd0,
		REG_INVERT      = 3'd1,
		REG_WIDE        = 3'd2,
		REG_STORED_BITS = 3'd3,
		REG_TOP_BIT     = 3'd4,
		REG_SIGNED      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic       byte_swap_enable;
		logic       invert_enable;
		logic       wide_samples;
		logic [4:0] stored_bits;
		logic [3:0] top_bit;
		logic       signed_samples;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		byte_swap_enable: 1'b0,
		invert_enable:    1'b0,
		wide_samples:     1'b1,
		stored_bits:      5'd16,
		top_bit:          4'd15,
		signed_samples:   1'b0
	};

endpackage
`default_nettype wire

// ===== src/mpsn_cfg.sv =====
// configuration register file of the pixel sample normalizer
`default_nettype none
module mpsn_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [mpsn_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [mpsn_pkg::CfgDataW-1:0] cfg_data,
	output mpsn_pkg::cfg_t                     cfg
);

	mpsn_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mpsn_pkg::CfgReset;
		end else if (cfg_valid) begin
			unique case (mpsn_pkg::reg_idx_t'(cfg_index))
				mpsn_pkg::REG_BYTE_SWAP:   cfg_q.byte_swap_enable <= cfg_data[0];
				mpsn_pkg::REG_INVERT:      cfg_q.invert_enable    <= cfg_data[0];
				mpsn_pkg::REG_WIDE:        cfg_q.wide_samples     <= cfg_data[0];
				mpsn_pkg::REG_STORED_BITS: cfg_q.stored_bits      <= cfg_data;
				mpsn_pkg::REG_TOP_BIT:     cfg_q.top_bit          <= cfg_data[3:0];
				mpsn_pkg::REG_SIGNED:      cfg_q.signed_samples   <= cfg_data[0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/mpsn_norm.sv =====
// combinational swap, inversion and stored-bit extraction of one sample
`default_nettype none
module mpsn_norm (
	input  wire mpsn_pkg::cfg_t                cfg,
	input  wire logic [mpsn_pkg::SampleW-1:0]  sample_raw,
	output logic [mpsn_pkg::SampleW-1:0]       sample_norm
);

	logic [4:0]  st;
	logic [16:0] mask_w;
	logic [15:0] mask;
	logic [15:0] swapped;
	logic [15:0] inverted;
	logic [4:0]  hi;
	logic [3:0]  sh;
	logic [15:0] shifted;
	logic [3:0]  sign_idx;
	logic [15:0] ext;
	logic [15:0] wide_res;
	logic [7:0]  narrow_res;

	always_comb begin
		// clamp stored bits to 1..16
		if (cfg.stored_bits == 5'd0)
			st = 5'd1;
		else if (cfg.stored_bits > 5'd16)
			st = 5'd16;
		else
			st = cfg.stored_bits;

		mask_w = (17'd1 << st) - 17'd1;
		mask   = mask_w[15:0];

		swapped = cfg.byte_swap_enable ? {sample_raw[7:0], sample_raw[15:8]} : sample_raw;

		if (!cfg.invert_enable)
			inverted = swapped;
		else if (cfg.signed_samples)
			inverted = ~swapped;
		else
			inverted = mask - swapped;

		// shift so the top stored bit lands at st-1
		hi = {1'b0, cfg.top_bit} + 5'd1;
		sh = (hi > st) ? 4'(hi - st) : 4'd0;
		shifted = inverted >> sh;

		sign_idx = 4'(st - 5'd1);
		ext      = 16'hffff << sign_idx;

		if (st < 5'd16) begin
			if (cfg.signed_samples && shifted[sign_idx])
				wide_res = shifted | ext;
			else
				wide_res = shifted & mask;
		end else begin
			wide_res = inverted;
		end

		narrow_res = cfg.invert_enable ? ~sample_raw[7:0] : sample_raw[7:0];

		sample_norm = cfg.wide_samples ? wide_res : {8'h00, narrow_res};
	end

endmodule
`default_nettype wire

// ===== src/medical_pixel_sample_normalizer.sv =====
// top level of the grey pixel sample normalizer
// an accepted word passes through the input register and then the result register to the output
// throughput: one word per cycle sustained, limited only by downstream ready
// in_ready falls only when both the input and the result register hold a waiting word
// reset: arst_n asynchronous, clears both valid flags and loads the register defaults
// (16-bit unsigned samples, 16 stored bits, top bit 15, no swap, no inversion)
`default_nettype none
module medical_pixel_sample_normalizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mpsn_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [mpsn_pkg::CfgDataW-1:0] cfg_data,
	// sample input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mpsn_pkg::SampleW-1:0]  sample_in,
	// sample output channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mpsn_pkg::SampleW-1:0]       sample_out
);

	mpsn_pkg::cfg_t cfg;

	// stage 1: raw sample register
	logic                         valid_s1;
	logic [mpsn_pkg::SampleW-1:0] sample_s1;
	// stage 2: result register feeding the output ports
	logic                         valid_s2;
	logic [mpsn_pkg::SampleW-1:0] sample_s2;

	logic                         adv_s2;
	logic                         adv_s1;
	logic [mpsn_pkg::SampleW-1:0] norm_word;

	// registers always writable; user writes only while stream is idle, block does not enforce it
	assign cfg_ready = 1'b1;

	mpsn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg
	);

	// result register can take a word when empty or draining this cycle
	assign adv_s2   = !valid_s2 || out_ready;
	// input register can take a word when empty or passing its word on
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid)
			sample_s1 <= sample_in;
		if (adv_s2 && valid_s1)
			sample_s2 <= norm_word;
	end

	// swap, invert, extract stored bits between the two registers
	mpsn_norm u_norm (
		.cfg,
		.sample_raw  (sample_s1),
		.sample_norm (norm_word)
	);

	assign out_valid  = valid_s2;
	assign sample_out = sample_s2;

endmodule
`default_nettype wire

// ===== src/mpsn_checker.sv =====
// port-level checks of the pixel sample normalizer and their binding
`default_nettype none
module mpsn_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [mpsn_pkg::SampleW-1:0]  sample_out
);

	// nothing valid on the output while reset is held
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a fresh output word comes from an accepted input word that passed through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output word without matching input two cycles before");

	// a stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled output word changed");

	// taking a word behind a stalled output fills both registers
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
		else $error("input ready with both registers full");

endmodule

bind medical_pixel_sample_normalizer mpsn_checker u_mpsn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);
`default_nettype wire

// ===== test/medical_pixel_sample_normalizer_checker.sv =====
// checker: tracks register writes, predicts each normalized sample and compares outputs
`timescale 1ns / 1ps
module medical_pixel_sample_normalizer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mpsn_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mpsn_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [mpsn_pkg::SampleW-1:0]  sample_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [mpsn_pkg::SampleW-1:0]  sample_out,
	output int                            pending,
	output int                            failures
);

	typedef struct packed {
		logic       swap;
		logic       invert;
		logic       wide;
		logic [4:0] stored;
		logic [3:0] top_pos;
		logic       sgn;
	} norm_regs_t;

	localparam norm_regs_t RegsAtReset = '{1'b0, 1'b0, 1'b1, 5'd16, 4'd15, 1'b0};

	norm_regs_t  regs;
	logic [15:0] expected_samples[$];
	logic [15:0] want;

	function automatic logic [15:0] normalize_sample(input norm_regs_t r, input logic [15:0] raw);
		logic [15:0] v;
		logic [15:0] keep;
		int unsigned st;
		int unsigned sh;
		if (!r.wide) begin
			v = {8'h00, raw[7:0]};
			if (r.invert) v[7:0] = 8'hff - raw[7:0];
			return v;
		end
		// stored count of zero behaves as one, anything past 16 as 16
		st = (r.stored == 0) ? 1 : (r.stored > 16) ? 16 : r.stored;
		keep = (st >= 16) ? 16'hffff : 16'((32'd1 << st) - 1);
		v = r.swap ? {raw[7:0], raw[15:8]} : raw;
		if (r.invert) v = r.sgn ? 16'hffff - v : keep - v;
		if (st < 16) begin
			sh = (r.top_pos + 1 > st) ? r.top_pos + 1 - st : 0;
			v = v >> sh;
			if (r.sgn && v[st-1]) v = v | (16'hffff << (st - 1));
			else v = v & keep;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= RegsAtReset;
			expected_samples.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					if (failures < 10) $display("unexpected output word %h", sample_out);
					failures <= failures + 1;
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						if (failures < 10)
							$display("sample_out mismatch: expected %h got %h", want, sample_out);
						failures <= failures + 1;
					end
				end
			end
			if (in_valid && in_ready) expected_samples.push_back(normalize_sample(regs, sample_in));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mpsn_pkg::REG_BYTE_SWAP:   regs.swap <= cfg_data[0];
					mpsn_pkg::REG_INVERT:      regs.invert <= cfg_data[0];
					mpsn_pkg::REG_WIDE:        regs.wide <= cfg_data[0];
					mpsn_pkg::REG_STORED_BITS: regs.stored <= cfg_data;
					mpsn_pkg::REG_TOP_BIT:     regs.top_pos <= cfg_data[3:0];
					mpsn_pkg::REG_SIGNED:      regs.sgn <= cfg_data[0];
					default: ;
				endcase
			end
			pending <= expected_samples.size();
		end
	end

endmodule

// ===== test/medical_pixel_sample_normalizer_tb.sv =====
// testbench top: drives registers and sample words, gives the verdict
`timescale 1ns / 1ps
module medical_pixel_sample_normalizer_tb;

	// generous bound for the watchdog
	localparam int unsigned CycleLimit = 400000;
	// input and result register pipeline, leave room to catch stray output words
	localparam int unsigned SettleCycles = 8;
	// indexes the block does not map; writes to them must be dropped
	localparam logic [mpsn_pkg::CfgIdxW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [mpsn_pkg::CfgIdxW-1:0] REG_SPARE_B = 3'd7;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mpsn_pkg::CfgIdxW-1:0]  cfg_index;
	logic [mpsn_pkg::CfgDataW-1:0] cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [mpsn_pkg::SampleW-1:0]  sample_in;
	logic                          out_valid;
	logic                          out_ready;
	logic [mpsn_pkg::SampleW-1:0]  sample_out;
	int                            pending;
	int                            failures;
	int unsigned                   cycle_count;
	// percent chance per cycle that the sender idles or the receiver stalls
	int unsigned                   tx_gap_pct;
	int unsigned                   rx_stall_pct;

	medical_pixel_sample_normalizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	medical_pixel_sample_normalizer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.pending    (pending),
		.failures   (failures)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("medical_pixel_sample_normalizer_tb NOT OK");
			$finish;
		end
	end

	// cfg_valid is left high so back-to-back writes never see a low-high pair in one step
	task automatic write_reg(input logic [mpsn_pkg::CfgIdxW-1:0] idx,
			input logic [mpsn_pkg::CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set; unused upper data bits of narrow registers get noise
	task automatic program_regs(input logic swap, input logic inv, input logic wide,
			input logic [4:0] stored, input logic [3:0] top_pos, input logic sgn);
		write_reg(mpsn_pkg::REG_BYTE_SWAP, {4'($urandom), swap});
		write_reg(mpsn_pkg::REG_INVERT, {4'($urandom), inv});
		write_reg(mpsn_pkg::REG_WIDE, {4'($urandom), wide});
		write_reg(mpsn_pkg::REG_STORED_BITS, stored);
		write_reg(mpsn_pkg::REG_TOP_BIT, {1'($urandom), top_pos});
		write_reg(mpsn_pkg::REG_SIGNED, {4'($urandom), sgn});
		// unmapped index, must leave every register alone
		write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 5'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// in_valid stays high on return so the next word can follow without a bubble
	task automatic send_sample(input logic [15:0] word);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= word;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every predicted word has come out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int unsigned count;
		logic [15:0] word;
		logic [4:0]  stored;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		out_ready <= 1'b0;
		cycle_count <= 0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: 16-bit unsigned, full width passes straight through
		send_sample(16'h0000);
		send_sample(16'hffff);
		send_sample(16'h8000);
		send_sample(16'h0001);
		drain_outputs();

		// swap then invert against the full 16-bit mask
		program_regs(1'b1, 1'b1, 1'b1, 5'd16, 4'd15, 1'b0);
		send_sample(16'h1234);
		send_sample(16'hff00);
		drain_outputs();

		// 8-bit samples: swap ignored, inversion is 255 minus the low byte even when signed
		program_regs(1'b1, 1'b1, 1'b0, 5'd16, 4'd15, 1'b1);
		send_sample(16'h00ff);
		send_sample(16'hab00);
		send_sample(16'h1280);
		drain_outputs();

		// signed 12-bit with inversion from 65535, sign extension on bit 11
		program_regs(1'b0, 1'b1, 1'b1, 5'd12, 4'd11, 1'b0 | 1'b1);
		send_sample(16'h0800);
		send_sample(16'h07ff);
		send_sample(16'hffff);
		drain_outputs();

		// unsigned 12-bit stored high: shift by four, mask minus sample wraps
		program_regs(1'b0, 1'b1, 1'b1, 5'd12, 4'd15, 1'b0);
		send_sample(16'hf000);
		send_sample(16'h0010);
		drain_outputs();

		// stored of zero acts as one bit, signed so a set bit fills the word
		program_regs(1'b1, 1'b0, 1'b1, 5'd0, 4'd0, 1'b1);
		send_sample(16'h0001);
		send_sample(16'h0100);
		send_sample(16'h0000);
		drain_outputs();

		// stored above 16 acts as 16, no cleanup at all
		program_regs(1'b0, 1'b0, 1'b1, 5'd31, 4'd15, 1'b1);
		send_sample(16'h8001);
		drain_outputs();

		// top bit below stored field: shift clamps at zero
		program_regs(1'b0, 1'b0, 1'b1, 5'd8, 4'd3, 1'b1);
		send_sample(16'h00f0);
		send_sample(16'h0080);
		drain_outputs();

		// random phases, rotating through the idling patterns
		for (int phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 74; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 74; end
				default: begin tx_gap_pct = 24; rx_stall_pct = 24; end
			endcase
			// mostly legal stored counts, sometimes the full 5-bit range
			case ($urandom_range(5))
				0: stored = 5'd16;
				1: stored = 5'($urandom_range(31));
				default: stored = 5'($urandom_range(15, 1));
			endcase
			program_regs(1'($urandom), 1'($urandom), $urandom_range(3) != 0, stored,
				4'($urandom), 1'($urandom));
			count = 100 + $urandom_range(40);
			for (int i = 0; i < count; i++) begin
				case ($urandom_range(7))
					0: word = 16'h0000;
					1: word = 16'hffff;
					2: word = $urandom_range(1) ? 16'h8000 : 16'h7fff;
					3: word = 16'h0001 << $urandom_range(15);
					default: word = 16'($urandom);
				endcase
				send_sample(word);
				// let the pipe run dry mid-stream now and then
				if (phase % 2 == 1 && i == count / 2) drain_outputs();
			end
			drain_outputs();
		end

		repeat (SettleCycles) @(posedge clk);
		if (failures == 0)
			$display("medical_pixel_sample_normalizer_tb OK");
		else
			$display("medical_pixel_sample_normalizer_tb NOT OK");
		$finish;
	end

endmodule
